// File: rtl/core/circular_first_fit_allocator_assert.svh
// Assertion macros used by the allocator RTL.
`ifndef CIRCULAR_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define CIRCULAR_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CFFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/cffa_pkg.sv
// Types, constants and control ROM for the circular first-fit allocator.
package cffa_pkg;

  localparam int ARENA_WORDS = 4096;
  localparam int ADDR_W      = $clog2(ARENA_WORDS);
  localparam int NEED_W      = ADDR_W + 1;
  localparam int GUARD_W     = ADDR_W + 1;
  localparam int WALK_LIMIT  = 2 * ARENA_WORDS + 4;
  localparam int STEPS_W     = $clog2(WALK_LIMIT + 2);
  localparam int STEP_W      = 4;

  localparam logic [ADDR_W-1:0]  SENTINEL   = ADDR_W'(ARENA_WORDS - 1);
  localparam logic [GUARD_W-1:0] GUARD_MAX  = GUARD_W'(ARENA_WORDS);
  localparam logic [STEPS_W-1:0] STEPS_MAX  = STEPS_W'(WALK_LIMIT);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic              op;
    logic [ADDR_W-1:0] size_words;
    logic [ADDR_W-1:0] address;
  } cffa_in_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] result_address;
  } cffa_out_t;

  typedef struct packed {
    logic              busy;
    logic [ADDR_W-1:0] next;
  } cffa_hdr_t;

  localparam int HDR_W = $bits(cffa_hdr_t);

  typedef logic [STEP_W-1:0] cffa_step_t;

  localparam cffa_step_t S_CLR   = 4'd0;
  localparam cffa_step_t S_IDLE  = 4'd1;
  localparam cffa_step_t S_DISP  = 4'd2;
  localparam cffa_step_t S_EVP   = 4'd3;
  localparam cffa_step_t S_RDQ   = 4'd4;
  localparam cffa_step_t S_EVQ   = 4'd5;
  localparam cffa_step_t S_FIT   = 4'd6;
  localparam cffa_step_t S_TAKE  = 4'd7;
  localparam cffa_step_t S_ADV   = 4'd8;
  localparam cffa_step_t S_FAIL  = 4'd9;
  localparam cffa_step_t S_F_CHK = 4'd10;
  localparam cffa_step_t S_F_WR  = 4'd11;
  localparam cffa_step_t S_F_BAD = 4'd12;
  localparam cffa_step_t S_DONE  = 4'd13;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_OUT_BUSY,
    C_CLR_MORE,
    C_IS_FREE,
    C_P_BUSY,
    C_MERGE_MORE,
    C_NO_FIT,
    C_WALK_ON,
    C_FREE_BAD
  } cffa_cond_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_CLR,
    ACT_ACCEPT,
    ACT_LOAD_Q,
    ACT_MERGE,
    ACT_FIT,
    ACT_TAKE,
    ACT_ADV,
    ACT_FAIL,
    ACT_FREE_OK,
    ACT_EMIT
  } cffa_act_t;

  typedef enum logic [3:0] {
    MEM_NONE,
    MEM_RD_P,
    MEM_RD_Q,
    MEM_RD_F,
    MEM_WR_MERGE,
    MEM_WR_CUT,
    MEM_WR_TAKE,
    MEM_WR_FREE,
    MEM_WR_CLR
  } cffa_mem_t;

  typedef struct packed {
    cffa_act_t  act;
    cffa_mem_t  mem;
    cffa_cond_t hold;
    cffa_cond_t jmp;
    cffa_step_t target;
  } cffa_ctrl_t;

  typedef struct packed {
    logic accept;
    logic out_busy;
    logic clr_more;
    logic is_free;
    logic p_busy;
    logic merge_more;
    logic no_fit;
    logic walk_on;
    logic free_bad;
  } cffa_flags_t;

  // Header contents right after reset.
  function automatic cffa_hdr_t hdr_reset(input logic [ADDR_W-1:0] idx);
    cffa_hdr_t h;
    h = '{busy: 1'b0, next: '0};
    if (idx == '0) begin
      h.next = SENTINEL;
    end else if (idx == SENTINEL) begin
      h.busy = 1'b1;
    end
    return h;
  endfunction

  // Microprogram: one control word per step.
  function automatic cffa_ctrl_t ucode_word(input cffa_step_t step);
    cffa_ctrl_t w;
    w = '{act: ACT_NONE, mem: MEM_NONE, hold: C_NEVER, jmp: C_NEVER, target: S_IDLE};
    case (step)
      S_CLR: begin
        w.act  = ACT_CLR;
        w.mem  = MEM_WR_CLR;
        w.hold = C_CLR_MORE;
      end
      S_IDLE: begin
        w.act  = ACT_ACCEPT;
        w.hold = C_NO_ACCEPT;
      end
      S_DISP: begin
        w.mem    = MEM_RD_P;
        w.jmp    = C_IS_FREE;
        w.target = S_F_CHK;
      end
      S_EVP: begin
        w.act    = ACT_LOAD_Q;
        w.jmp    = C_P_BUSY;
        w.target = S_ADV;
      end
      S_RDQ: begin
        w.mem = MEM_RD_Q;
      end
      S_EVQ: begin
        w.act    = ACT_MERGE;
        w.mem    = MEM_WR_MERGE;
        w.jmp    = C_MERGE_MORE;
        w.target = S_RDQ;
      end
      S_FIT: begin
        w.act    = ACT_FIT;
        w.mem    = MEM_WR_CUT;
        w.jmp    = C_NO_FIT;
        w.target = S_ADV;
      end
      S_TAKE: begin
        w.act    = ACT_TAKE;
        w.mem    = MEM_WR_TAKE;
        w.jmp    = C_ALWAYS;
        w.target = S_DONE;
      end
      S_ADV: begin
        w.act    = ACT_ADV;
        w.jmp    = C_WALK_ON;
        w.target = S_DISP;
      end
      S_FAIL: begin
        w.act    = ACT_FAIL;
        w.jmp    = C_ALWAYS;
        w.target = S_DONE;
      end
      S_F_CHK: begin
        w.mem    = MEM_RD_F;
        w.jmp    = C_FREE_BAD;
        w.target = S_F_BAD;
      end
      S_F_WR: begin
        w.act    = ACT_FREE_OK;
        w.mem    = MEM_WR_FREE;
        w.jmp    = C_ALWAYS;
        w.target = S_DONE;
      end
      S_F_BAD: begin
        w.act = ACT_FAIL;
      end
      S_DONE: begin
        w.act    = ACT_EMIT;
        w.hold   = C_OUT_BUSY;
        w.jmp    = C_ALWAYS;
        w.target = S_IDLE;
      end
      default: begin
        w.jmp    = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: rtl/core/cffa_ram.sv
// Single-port RAM with registered read data.
module cffa_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: rtl/core/cffa_seq.sv
// Microsequencer: step counter, control ROM and conditional jumps.
module cffa_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cffa_pkg::cffa_flags_t flags,
  output cffa_pkg::cffa_ctrl_t  ctrl
);

  cffa_pkg::cffa_step_t step_r;
  cffa_pkg::cffa_step_t step_nxt;

  function automatic logic cond_hit(input cffa_pkg::cffa_cond_t c,
                                    input cffa_pkg::cffa_flags_t f);
    logic hit;
    case (c)
      cffa_pkg::C_NEVER:      hit = 1'b0;
      cffa_pkg::C_ALWAYS:     hit = 1'b1;
      cffa_pkg::C_NO_ACCEPT:  hit = !f.accept;
      cffa_pkg::C_OUT_BUSY:   hit = f.out_busy;
      cffa_pkg::C_CLR_MORE:   hit = f.clr_more;
      cffa_pkg::C_IS_FREE:    hit = f.is_free;
      cffa_pkg::C_P_BUSY:     hit = f.p_busy;
      cffa_pkg::C_MERGE_MORE: hit = f.merge_more;
      cffa_pkg::C_NO_FIT:     hit = f.no_fit;
      cffa_pkg::C_WALK_ON:    hit = f.walk_on;
      cffa_pkg::C_FREE_BAD:   hit = f.free_bad;
      default:                hit = 1'b0;
    endcase
    return hit;
  endfunction

  always_comb begin
    ctrl = cffa_pkg::ucode_word(step_r);
    if (cond_hit(ctrl.hold, flags)) begin
      step_nxt = step_r;
    end else if (cond_hit(ctrl.jmp, flags)) begin
      step_nxt = ctrl.target;
    end else begin
      step_nxt = step_r + cffa_pkg::cffa_step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= cffa_pkg::S_CLR;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: rtl/core/circular_first_fit_allocator.sv
// Circular first-fit allocator: one item at a time, one header access per cycle.
// Free: reject address zero or the sentinel and above, else mark the block's header free.
// Allocate: walk the header chain from the roving cursor, merging free neighbors, and take
// the first fit or fail the walk; the single header RAM port paces every step.
// A held result stalls the last step until the output register drains.
// Reset: a clearing pass writes every header; in_ready stays low meanwhile.
`include "circular_first_fit_allocator_assert.svh"

module circular_first_fit_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cffa_pkg::cffa_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cffa_pkg::cffa_out_t out_data
);

  localparam int AW = cffa_pkg::ADDR_W;

  cffa_pkg::cffa_ctrl_t  ctrl;
  cffa_pkg::cffa_flags_t flags;
  cffa_pkg::cffa_hdr_t   rd;

  logic                  ram_en;
  logic                  ram_we;
  logic [AW-1:0]         ram_addr;
  logic [cffa_pkg::HDR_W-1:0] ram_wdata;
  logic [cffa_pkg::HDR_W-1:0] ram_rdata;

  // control state
  logic [AW-1:0] clr_cnt_r,  clr_cnt_nxt;
  logic [AW-1:0] cursor_r,   cursor_nxt;
  logic          out_valid_r, out_valid_nxt;

  // datapath
  logic                          op_r,    op_nxt;
  logic [cffa_pkg::NEED_W-1:0]   need_r,  need_nxt;
  logic [AW-1:0]                 addr_r,  addr_nxt;
  logic [AW-1:0]                 p_r,     p_nxt;
  logic [AW-1:0]                 q_r,     q_nxt;
  logic [cffa_pkg::GUARD_W-1:0]  guard_r, guard_nxt;
  logic [cffa_pkg::STEPS_W-1:0]  steps_r, steps_nxt;
  logic                          wraps_r, wraps_nxt;
  cffa_pkg::cffa_out_t           res_r,   res_nxt;
  cffa_pkg::cffa_out_t           out_data_r, out_data_nxt;

  logic                          accept;
  logic                          out_free;
  logic [cffa_pkg::NEED_W-1:0]   cut_w;
  logic [AW-1:0]                 cut;
  logic [AW-1:0]                 span;
  logic                          fit;
  logic                          merge_more;
  logic [cffa_pkg::STEPS_W-1:0]  steps_inc;
  logic                          wrap_now;
  logic                          walk_fail;
  logic [AW-1:0]                 free_idx;

  cffa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  cffa_ram #(
    .DEPTH (cffa_pkg::ARENA_WORDS),
    .WIDTH (cffa_pkg::HDR_W)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd        = cffa_pkg::cffa_hdr_t'(ram_rdata);
  assign in_ready  = (ctrl.act == cffa_pkg::ACT_ACCEPT);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign cut_w      = {1'b0, p_r} + need_r;
  assign cut        = cut_w[AW-1:0];
  assign span       = q_r - p_r;
  assign fit        = (q_r >= p_r) && ({1'b0, span} >= need_r);
  assign merge_more = !rd.busy && (guard_r != cffa_pkg::GUARD_MAX);
  assign steps_inc  = steps_r + cffa_pkg::STEPS_W'(1);
  assign wrap_now   = !(q_r > p_r);
  assign walk_fail  = (steps_inc > cffa_pkg::STEPS_MAX) || (wrap_now && wraps_r);
  assign free_idx   = addr_r - AW'(1);

  always_comb begin
    flags.accept     = accept;
    flags.out_busy   = out_valid_r && !out_ready;
    flags.clr_more   = (clr_cnt_r != cffa_pkg::SENTINEL);
    flags.is_free    = (op_r == cffa_pkg::OP_FREE);
    flags.p_busy     = rd.busy;
    flags.merge_more = merge_more;
    flags.no_fit     = !fit;
    flags.walk_on    = !walk_fail;
    flags.free_bad   = (addr_r == '0) || (addr_r >= cffa_pkg::SENTINEL);
  end

  // header RAM port
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = p_r;
    ram_wdata = '0;
    case (ctrl.mem)
      cffa_pkg::MEM_RD_P: begin
        ram_en = 1'b1;
      end
      cffa_pkg::MEM_RD_Q: begin
        ram_en   = 1'b1;
        ram_addr = q_r;
      end
      cffa_pkg::MEM_RD_F: begin
        ram_en   = 1'b1;
        ram_addr = free_idx;
      end
      cffa_pkg::MEM_WR_MERGE: begin
        ram_en    = merge_more;
        ram_we    = merge_more;
        ram_wdata = {1'b0, rd.next};
      end
      cffa_pkg::MEM_WR_CUT: begin
        // split off the remainder as a new free block
        ram_en    = fit && (q_r > cut);
        ram_we    = fit && (q_r > cut);
        ram_addr  = cut;
        ram_wdata = {1'b0, q_r};
      end
      cffa_pkg::MEM_WR_TAKE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = {1'b1, cut};
      end
      cffa_pkg::MEM_WR_FREE: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = free_idx;
        ram_wdata = {1'b0, rd.next};
      end
      cffa_pkg::MEM_WR_CLR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_r;
        ram_wdata = cffa_pkg::hdr_reset(clr_cnt_r);
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    cursor_nxt    = cursor_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    need_nxt      = need_r;
    addr_nxt      = addr_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    guard_nxt     = guard_r;
    steps_nxt     = steps_r;
    wraps_nxt     = wraps_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;

    // drop the output beat once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (ctrl.act)
      cffa_pkg::ACT_CLR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      cffa_pkg::ACT_ACCEPT: begin
        if (accept) begin
          op_nxt    = in_data.op;
          need_nxt  = {1'b0, in_data.size_words} + cffa_pkg::NEED_W'(1);
          addr_nxt  = in_data.address;
          p_nxt     = cursor_r;
          wraps_nxt = 1'b0;
          steps_nxt = '0;
        end
      end
      cffa_pkg::ACT_LOAD_Q: begin
        q_nxt     = rd.next;
        guard_nxt = '0;
      end
      cffa_pkg::ACT_MERGE: begin
        if (merge_more) begin
          q_nxt     = rd.next;
          guard_nxt = guard_r + cffa_pkg::GUARD_W'(1);
        end
      end
      cffa_pkg::ACT_FIT: begin
        if (fit) begin
          cursor_nxt = cut;
        end
      end
      cffa_pkg::ACT_TAKE: begin
        res_nxt.ok             = 1'b1;
        res_nxt.result_address = p_r + AW'(1);
      end
      cffa_pkg::ACT_ADV: begin
        p_nxt     = q_r;
        steps_nxt = steps_inc;
        if (wrap_now) begin
          wraps_nxt = 1'b1;
        end
      end
      cffa_pkg::ACT_FAIL: begin
        res_nxt.ok             = 1'b0;
        res_nxt.result_address = '0;
      end
      cffa_pkg::ACT_FREE_OK: begin
        res_nxt.ok             = 1'b1;
        res_nxt.result_address = '0;
      end
      cffa_pkg::ACT_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        clr_cnt_nxt = clr_cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_cnt_r   <= clr_cnt_nxt;
      cursor_r    <= cursor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    need_r     <= need_nxt;
    addr_r     <= addr_nxt;
    p_r        <= p_nxt;
    q_r        <= q_nxt;
    guard_r    <= guard_nxt;
    steps_r    <= steps_nxt;
    wraps_r    <= wraps_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `CFFA_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n,
    in_valid && in_ready, !in_ready, "input taken twice in a row")
  `CFFA_ASSERT_NOW(a_fail_zero_addr, clk, rst_n,
    out_valid && !out_data.ok, out_data.result_address == '0,
    "failed result carries an address")
  `CFFA_ASSERT_NOW(a_sentinel_kept, clk, rst_n,
    ram_we && (ctrl.mem != cffa_pkg::MEM_WR_CLR), ram_addr != cffa_pkg::SENTINEL,
    "sentinel header overwritten")

endmodule

// File: tb/circular_first_fit_allocator_test.sv
// Self-checking testbench for the circular first-fit allocator.
module circular_first_fit_allocator_test;

  localparam int OPENING_ROWS = 22;
  localparam int RANDOM_ITEMS = 1900;
  localparam int LONG_HOLD    = 800;

  typedef struct packed {
    logic                        op;
    logic [cffa_pkg::ADDR_W-1:0] size_words;
    logic [cffa_pkg::ADDR_W-1:0] address;
    logic                        typed;
    logic                        ok;
    logic [cffa_pkg::ADDR_W-1:0] result_address;
  } opening_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  cffa_pkg::cffa_in_t  in_data;
  logic                out_valid;
  logic                out_ready;
  cffa_pkg::cffa_out_t out_data;

  // Shadow arena: header links, busy bits and the roving cursor.
  logic [cffa_pkg::ADDR_W-1:0] link_of [cffa_pkg::ARENA_WORDS];
  bit                          taken   [cffa_pkg::ARENA_WORDS];
  logic [cffa_pkg::ADDR_W-1:0] rover;

  cffa_pkg::cffa_out_t         pending_results [$];
  cffa_pkg::cffa_out_t         oldest;
  logic [cffa_pkg::ADDR_W-1:0] live_blocks [$];
  logic [cffa_pkg::ADDR_W-1:0] last_freed;
  opening_row_t                opening_rows [OPENING_ROWS];
  int                          mismatches;
  int                          results_seen;
  int                          burst_left;
  bit                          long_hold_done;

  circular_first_fit_allocator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 5_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic void arena_clear();
    for (int i = 0; i < cffa_pkg::ARENA_WORDS; i++) begin
      link_of[i] = '0;
      taken[i]   = 1'b0;
    end
    link_of[0]                = cffa_pkg::SENTINEL;
    taken[cffa_pkg::SENTINEL] = 1'b1;
    rover                     = '0;
  endfunction

  // Walk the chain from the cursor, merge free runs, take the first fit.
  function automatic bit fit_search(input int need, output int where);
    int p;
    int q;
    int prev;
    int cut;
    int guard;
    int steps;
    bit wrapped;
    p       = rover;
    steps   = 0;
    wrapped = 1'b0;
    where   = 0;
    while (1) begin
      if (!taken[p]) begin
        q     = link_of[p];
        guard = 0;
        while (!taken[q] && guard < cffa_pkg::ARENA_WORDS) begin
          link_of[p] = link_of[q];
          q          = link_of[p];
          guard++;
        end
        if (q >= p && q - p >= need) begin
          cut   = p + need;
          rover = cut[cffa_pkg::ADDR_W-1:0];
          if (q > cut) begin
            link_of[cut] = link_of[p];
            taken[cut]   = 1'b0;
          end
          link_of[p] = cut[cffa_pkg::ADDR_W-1:0];
          taken[p]   = 1'b1;
          where      = p + 1;
          return 1'b1;
        end
      end
      prev = p;
      p    = link_of[p];
      steps++;
      if (steps > cffa_pkg::WALK_LIMIT) return 1'b0;
      if (p <= prev) begin
        if (wrapped) return 1'b0;
        wrapped = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic cffa_pkg::cffa_out_t arena_apply(input cffa_pkg::cffa_in_t beat);
    cffa_pkg::cffa_out_t r;
    int where;
    r = '0;
    if (beat.op == cffa_pkg::OP_ALLOC) begin
      if (fit_search(int'(beat.size_words) + 1, where)) begin
        r.ok             = 1'b1;
        r.result_address = where[cffa_pkg::ADDR_W-1:0];
      end
    end else if (beat.address != '0 && beat.address < cffa_pkg::SENTINEL) begin
      taken[beat.address - 1'b1] = 1'b0;
      r.ok                       = 1'b1;
    end
    return r;
  endfunction

  // Mostly frees of live blocks and small allocations; some noise frees.
  function automatic cffa_pkg::cffa_in_t next_request();
    cffa_pkg::cffa_in_t b;
    int roll;
    int pick;
    b.op         = cffa_pkg::OP_ALLOC;
    b.size_words = cffa_pkg::ADDR_W'($urandom_range(0, cffa_pkg::ARENA_WORDS - 1));
    b.address    = cffa_pkg::ADDR_W'($urandom_range(0, cffa_pkg::ARENA_WORDS - 1));
    roll         = $urandom_range(0, 99);
    if (live_blocks.size() != 0 && (roll < 42 || live_blocks.size() > 60)) begin
      pick       = $urandom_range(0, live_blocks.size() - 1);
      b.op       = cffa_pkg::OP_FREE;
      b.address  = live_blocks[pick];
      last_freed = b.address;
      live_blocks.delete(pick);
    end else if (roll < 90) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        b.size_words = cffa_pkg::ADDR_W'($urandom_range(0, 31));
      end else if (roll < 95) begin
        b.size_words = cffa_pkg::ADDR_W'($urandom_range(32, 300));
      end
    end else begin
      b.op = cffa_pkg::OP_FREE;
      case ($urandom_range(0, 4))
        0: b.address = '0;
        1: b.address = cffa_pkg::SENTINEL;
        2: b.address = last_freed;
        3: b.address = last_freed + 1'b1;
        default: ;
      endcase
    end
    return b;
  endfunction

  // Present one beat, wait for the handshake, then maybe open an idle gap.
  task automatic offer_beat(input cffa_pkg::cffa_in_t beat, input bit typed,
                            input cffa_pkg::cffa_out_t typed_res,
                            output cffa_pkg::cffa_out_t got);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = arena_apply(beat);
    pending_results.push_back(typed ? typed_res : got);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 14)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic settle_outputs();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    cffa_pkg::cffa_in_t  beat;
    cffa_pkg::cffa_out_t got;
    cffa_pkg::cffa_out_t typed_res;
    int                  counted;
    bit                  paused;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    counted    = 0;
    paused     = 1'b0;
    burst_left = 1;
    last_freed = '0;
    opening_rows = '{
      '{cffa_pkg::OP_ALLOC,    0,    0, 1'b1, 1'b1, 1},  // whole arena free: first data word
      '{cffa_pkg::OP_ALLOC, 4094,    0, 1'b1, 1'b0, 0},  // one word short: wraps twice
      '{cffa_pkg::OP_FREE,     0,    0, 1'b1, 1'b0, 0},  // address zero ignored
      '{cffa_pkg::OP_FREE,     0, 4095, 1'b1, 1'b0, 0},  // sentinel ignored
      '{cffa_pkg::OP_FREE,     0,    1, 1'b1, 1'b1, 0},
      '{cffa_pkg::OP_ALLOC, 4094,    0, 1'b1, 1'b1, 1},  // exact fit after merge
      '{cffa_pkg::OP_ALLOC,    0,    0, 1'b1, 1'b0, 0},  // arena full
      '{cffa_pkg::OP_ALLOC, 4095, 4095, 1'b1, 1'b0, 0},  // larger than the arena
      '{cffa_pkg::OP_FREE,  4095, 4094, 1'b1, 1'b1, 0},  // last word below the sentinel
      '{cffa_pkg::OP_FREE,     0,    1, 1'b1, 1'b1, 0},
      '{cffa_pkg::OP_ALLOC,   10,    0, 1'b0, 1'b0, 0},
      '{cffa_pkg::OP_ALLOC,   20,    0, 1'b0, 1'b0, 0},
      '{cffa_pkg::OP_ALLOC,   30,    0, 1'b0, 1'b0, 0},
      '{cffa_pkg::OP_ALLOC,    5,    0, 1'b0, 1'b0, 0},
      '{cffa_pkg::OP_FREE,     0,   12, 1'b0, 1'b0, 0},
      '{cffa_pkg::OP_FREE,     0,   12, 1'b0, 1'b0, 0},  // double free
      '{cffa_pkg::OP_FREE,     0,   33, 1'b0, 1'b0, 0},  // neighbor, merged on a later walk
      '{cffa_pkg::OP_FREE,     0,    3, 1'b0, 1'b0, 0},  // word inside a block
      '{cffa_pkg::OP_ALLOC,   45,    0, 1'b0, 1'b0, 0},
      '{cffa_pkg::OP_ALLOC, 4000,    0, 1'b0, 1'b0, 0},
      '{cffa_pkg::OP_FREE,     0, 4094, 1'b0, 1'b0, 0},
      '{cffa_pkg::OP_ALLOC, 2047, 2730, 1'b0, 1'b0, 0}
    };
    arena_clear();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    foreach (opening_rows[i]) begin
      beat.op                  = opening_rows[i].op;
      beat.size_words          = opening_rows[i].size_words;
      beat.address             = opening_rows[i].address;
      typed_res.ok             = opening_rows[i].ok;
      typed_res.result_address = opening_rows[i].result_address;
      offer_beat(beat, opening_rows[i].typed, typed_res, got);
    end
    settle_outputs();

    while (counted < RANDOM_ITEMS) begin
      beat = next_request();
      offer_beat(beat, 1'b0, '0, got);
      if (beat.op == cffa_pkg::OP_ALLOC && got.ok) live_blocks.push_back(got.result_address);
      if (!(beat.op == cffa_pkg::OP_FREE &&
            (beat.address == '0 || beat.address >= cffa_pkg::SENTINEL))) begin
        counted++;
      end
      if (!paused && counted >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        settle_outputs();
      end
    end

    settle_outputs();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Receiver: switch between stall patterns; hold off once for a long stretch.
  initial begin : result_drain
    int phase_left;
    int mode;
    out_ready      = 1'b0;
    long_hold_done = 1'b0;
    phase_left     = 0;
    mode           = 0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (phase_left == 0) begin
          mode       = $urandom_range(0, 2);
          phase_left = $urandom_range(8, 80);
        end
        phase_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: ok %0d result_address %0d",
               out_data.ok, out_data.result_address);
        mismatches++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_data.ok !== oldest.ok) begin
          $error("ok: expected %0d, got %0d", oldest.ok, out_data.ok);
          mismatches++;
        end
        if (out_data.result_address !== oldest.result_address) begin
          $error("result_address: expected %0d, got %0d",
                 oldest.result_address, out_data.result_address);
          mismatches++;
        end
        results_seen++;
      end
    end
  end

endmodule
